// File: sv/lba_pkg.sv
`default_nettype none

package lba_pkg;

  localparam int unsigned AccW   = 32;
  localparam int unsigned DecayW = 16;
  localparam int unsigned CountW = 8;
  localparam int unsigned LagW   = 8;

  localparam logic [DecayW-1:0] DecayReset = DecayW'(65309);
  localparam logic [AccW:0]     OneQ20     = (AccW+1)'(1) << 20;
  localparam logic [AccW-1:0]   AccMax     = '1;

  localparam logic CmdAdvance = 1'b0;
  localparam logic CmdRead    = 1'b1;

  typedef struct packed {
    logic step;
    logic sample;
  } cell_ctl_t;

endpackage

`default_nettype wire

// File: sv/lba_cell.sv
`default_nettype none

module lba_cell (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  lba_pkg::cell_ctl_t            ctl_i,
  input  wire [lba_pkg::DecayW-1:0]     decay_i,
  input  wire                           hist_i,
  output logic                          hist_o,
  output logic [lba_pkg::AccW-1:0]      acc_o
);
  import lba_pkg::*;

  logic                     hist_q, hist_d;
  logic [AccW-1:0]          acc_q, acc_d;
  logic [AccW+DecayW-1:0]   product;
  logic [AccW:0]            sum;

  always_comb begin
    product = acc_q * decay_i;
    sum     = {1'b0, product[AccW+DecayW-1:DecayW]};
    if (ctl_i.sample && hist_q) begin
      sum = sum + OneQ20;
    end
    hist_d = hist_q;
    acc_d  = acc_q;
    if (ctl_i.step) begin
      hist_d = hist_i;
      acc_d  = sum[AccW] ? AccMax : sum[AccW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= 1'b0;
      acc_q  <= '0;
    end else begin
      hist_q <= hist_d;
      acc_q  <= acc_d;
    end
  end

  assign hist_o = hist_q;
  assign acc_o  = acc_q;

endmodule

`default_nettype wire

// File: sv/leaky_binary_autocorrelation.sv
// Leaky binary autocorrelation over a stream of one-bit sensor samples.
// Input channel (in_valid_i/in_ready_o): an advance transfer (command 0)
// applies sample_bit_i repeat_count_i times; a read transfer (command 1)
// returns the accumulator of lag lag_select_i + 1 on the output channel
// (out_valid_o/out_ready_i), or zero when the lag is out of range.
// Configuration channel (cfg_valid_i/cfg_ready_o) writes the Q0.16 decay
// factor; it is always ready, and the user must write it only while the block is
// idle, which the block itself does not enforce. A row of LAGS cells, one per
// lag, holds the sample history as a shift line and the Q12.20 accumulators;
// the whole row takes one step per cycle while an advance runs. An advance
// with repeat count N takes N steps, none for N zero: the first step is taken
// in the transfer cycle and in_ready_o is low until the rest are done. A
// read's result appears in the output register on the next cycle. When the
// receiver stalls, the result is held and a new input transfer is taken only
// in a cycle where the output register is free or being emptied. Reset clears
// the history and all accumulators and loads the decay factor's default 65309.
`default_nettype none

module leaky_binary_autocorrelation #(
  parameter int unsigned LAGS = 200
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           in_valid_i,
  output logic                          in_ready_o,
  input  wire                           command_i,
  input  wire                           sample_bit_i,
  input  wire [lba_pkg::CountW-1:0]     repeat_count_i,
  input  wire [lba_pkg::LagW-1:0]       lag_select_i,
  output logic                          out_valid_o,
  input  wire                           out_ready_i,
  output logic [lba_pkg::LagW-1:0]      lag_echo_o,
  output logic [lba_pkg::AccW-1:0]      correlation_o,
  input  wire                           cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire [lba_pkg::DecayW-1:0]     cfg_data_i
);
  import lba_pkg::*;

  localparam int unsigned IdxW = (LAGS > 1) ? $clog2(LAGS) : 1;

  logic [DecayW-1:0]  decay_q, decay_d;
  logic [CountW-1:0]  remain_q, remain_d;
  logic               bit_q, bit_d;
  logic               out_valid_q, out_valid_d;
  logic [LagW-1:0]    lag_echo_q, lag_echo_d;
  logic [AccW-1:0]    corr_q, corr_d;

  logic               busy;
  logic               in_xfer;
  logic               start_step;
  cell_ctl_t          ctl;
  logic [LAGS:0]      hist_chain;
  logic [AccW-1:0]    acc_w [LAGS];
  logic [IdxW+LagW-1:0] lag_wide;
  logic [IdxW-1:0]    lag_idx;
  logic               lag_valid;

  assign busy       = (remain_q != '0);
  assign in_ready_o = !busy && (!out_valid_q || out_ready_i);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign start_step = in_xfer && (command_i == CmdAdvance) && (repeat_count_i != '0);

  assign ctl.step   = busy || start_step;
  assign ctl.sample = busy ? bit_q : sample_bit_i;

  assign hist_chain[0] = ctl.sample;

  for (genvar g = 0; g < LAGS; g++) begin : g_cell
    lba_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .decay_i (decay_q),
      .hist_i  (hist_chain[g]),
      .hist_o  (hist_chain[g+1]),
      .acc_o   (acc_w[g])
    );
  end

  assign lag_wide  = {{IdxW{1'b0}}, lag_select_i};
  assign lag_idx   = lag_wide[IdxW-1:0];
  assign lag_valid = (32'(lag_wide) < LAGS);

  always_comb begin
    decay_d     = cfg_valid_i ? cfg_data_i : decay_q;
    remain_d    = remain_q;
    bit_d       = bit_q;
    out_valid_d = out_valid_q && !out_ready_i;
    lag_echo_d  = lag_echo_q;
    corr_d      = corr_q;
    if (busy) begin
      remain_d = remain_q - CountW'(1);
    end else if (start_step) begin
      remain_d = repeat_count_i - CountW'(1);
      bit_d    = sample_bit_i;
    end
    if (in_xfer && (command_i == CmdRead)) begin
      out_valid_d = 1'b1;
      lag_echo_d  = lag_select_i;
      corr_d      = lag_valid ? acc_w[lag_idx] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decay_q     <= DecayReset;
      remain_q    <= '0;
      bit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      decay_q     <= decay_d;
      remain_q    <= remain_d;
      bit_q       <= bit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lag_echo_q <= lag_echo_d;
    corr_q     <= corr_d;
  end

  assign cfg_ready_o   = 1'b1;
  assign out_valid_o   = out_valid_q;
  assign lag_echo_o    = lag_echo_q;
  assign correlation_o = corr_q;

endmodule

`default_nettype wire

// File: sv/lba_checker.sv
`default_nettype none

module lba_checker #(
  parameter int unsigned LAGS = 200
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           in_valid_i,
  input  wire                           in_ready_o,
  input  wire                           command_i,
  input  wire                           sample_bit_i,
  input  wire [lba_pkg::CountW-1:0]     repeat_count_i,
  input  wire [lba_pkg::LagW-1:0]       lag_select_i,
  input  wire                           out_valid_o,
  input  wire                           out_ready_i,
  input  wire [lba_pkg::LagW-1:0]       lag_echo_o,
  input  wire [lba_pkg::AccW-1:0]       correlation_o,
  input  wire                           cfg_valid_i,
  input  wire                           cfg_ready_o,
  input  wire [lba_pkg::DecayW-1:0]     cfg_data_i
);
  import lba_pkg::*;

  logic read_xfer;
  logic long_advance;

  assign read_xfer    = in_valid_i && in_ready_o && (command_i == CmdRead);
  assign long_advance = in_valid_i && in_ready_o && (command_i == CmdAdvance)
                        && (repeat_count_i > CountW'(1));

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(lag_echo_o)
      && $stable(correlation_o))
    else $error("Output result changed while stalled.");

  a_read_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    read_xfer |=> out_valid_o && (lag_echo_o == $past(lag_select_i)))
    else $error("Read transfer did not produce its result.");

  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    read_xfer && (32'(lag_select_i) >= LAGS) |=> correlation_o == '0)
    else $error("Out of range lag returned a nonzero value.");

  a_repeat_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    long_advance |=> !in_ready_o)
    else $error("Input accepted while repeated steps remain.");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(read_xfer))
    else $error("Result appeared without a read transfer.");

endmodule

bind leaky_binary_autocorrelation lba_checker #(.LAGS(LAGS)) u_lba_checker (.*);

`default_nettype wire

// File: sim/leaky_binary_autocorrelation_tb.sv
`timescale 1ns / 100ps

module leaky_binary_autocorrelation_tb;
  import lba_pkg::*;

  localparam int unsigned NumLags      = 200;
  localparam int unsigned SettleCycles = 270;
  localparam int unsigned MaxPrinted   = 100;
  localparam longint      LimitNs      = 20_000_000;

  localparam int unsigned IdleNone     = 0;
  localparam int unsigned IdleSender   = 1;
  localparam int unsigned IdleReceiver = 2;
  localparam int unsigned IdleBoth     = 3;

  class lag_scoreboard #(int unsigned Depth = 200);
    typedef struct packed {
      logic [LagW-1:0] lag;
      logic [AccW-1:0] corr;
    } read_result_t;

    logic              history [Depth];
    logic [AccW-1:0]   acc [Depth];
    int unsigned       wpos;
    logic [DecayW-1:0] decay;
    read_result_t      pending_reads [$];
    int unsigned       errors;

    function new();
      for (int j = 0; j < Depth; j++) begin
        history[j] = 1'b0;
        acc[j] = '0;
      end
      wpos = 0;
      decay = DecayReset;
      errors = 0;
    endfunction

    function void set_decay(logic [DecayW-1:0] value);
      decay = value;
    endfunction

    function void take_step(logic smp);
      logic [AccW+DecayW-1:0] prod;
      logic [AccW:0]          sum;
      int unsigned            back;
      for (int j = 0; j < Depth; j++) begin
        back = (wpos + Depth - (j + 1)) % Depth;
        prod = acc[j] * decay;
        sum = {1'b0, prod[AccW+DecayW-1:DecayW]};
        if (smp && history[back]) sum = sum + ((AccW+1)'(1) << 20);
        acc[j] = sum[AccW] ? AccMax : sum[AccW-1:0];
      end
      history[wpos] = smp;
      wpos = (wpos + 1) % Depth;
    endfunction

    function void note_input(logic cmd, logic smp, logic [CountW-1:0] rep,
                             logic [LagW-1:0] lag);
      read_result_t r;
      if (cmd == CmdRead) begin
        r.lag = lag;
        r.corr = (lag < Depth) ? acc[lag] : '0;
        pending_reads.push_back(r);
      end else begin
        for (int i = 0; i < rep; i++) take_step(smp);
      end
    endfunction

    task report(string msg);
      if (errors < MaxPrinted) $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_read(logic [LagW-1:0] lag, logic [AccW-1:0] corr);
      read_result_t e;
      if (pending_reads.size() == 0) begin
        report($sformatf("unexpected result lag %0d correlation %h", lag, corr));
        return;
      end
      e = pending_reads.pop_front();
      if (lag !== e.lag)
        report($sformatf("lag_echo %0d, expected %0d", lag, e.lag));
      if (corr !== e.corr)
        report($sformatf("correlation %h, expected %h (lag %0d)", corr, e.corr, e.lag));
    endtask
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic              command_i;
  logic              sample_bit_i;
  logic [CountW-1:0] repeat_count_i;
  logic [LagW-1:0]   lag_select_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [LagW-1:0]   lag_echo_o;
  logic [AccW-1:0]   correlation_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [DecayW-1:0] cfg_data_i;

  lag_scoreboard #(NumLags) sb;
  int unsigned idle_mode;
  int unsigned hold_cycles;

  leaky_binary_autocorrelation #(
    .LAGS(NumLags)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .sample_bit_i  (sample_bit_i),
    .repeat_count_i(repeat_count_i),
    .lag_select_i  (lag_select_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .lag_echo_o    (lag_echo_o),
    .correlation_o (correlation_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit sender_pauses();
    if (idle_mode == IdleSender) return $urandom_range(99) < 49;
    if (idle_mode == IdleBoth) return $urandom_range(99) < 24;
    return 1'b0;
  endfunction

  function automatic bit receiver_stalls();
    if (idle_mode == IdleReceiver) return $urandom_range(99) < 49;
    if (idle_mode == IdleBoth) return $urandom_range(99) < 24;
    return 1'b0;
  endfunction

  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        out_ready_i = 1'b0;
        hold_cycles--;
      end else begin
        out_ready_i = !receiver_stalls();
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) sb.check_read(lag_echo_o, correlation_o);
    end
  end

  initial begin
    #(LimitNs);
    $display("DONE: errors detected");
    $finish;
  end

  task automatic send_item(input logic cmd, input logic smp, input logic [CountW-1:0] rep,
                           input logic [LagW-1:0] lag);
    @(negedge clk_i);
    while (sender_pauses()) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    command_i = cmd;
    sample_bit_i = smp;
    repeat_count_i = rep;
    lag_select_i = lag;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(cmd, smp, rep, lag);
  endtask

  task automatic read_lag(input logic [LagW-1:0] lag);
    send_item(CmdRead, 1'($urandom), 8'($urandom), lag);
  endtask

  task automatic advance(input logic smp, input logic [CountW-1:0] rep);
    send_item(CmdAdvance, smp, rep, 8'($urandom));
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending_reads.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_decay(input logic [DecayW-1:0] value);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_decay(value);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic run_random(input int unsigned count);
    logic              cmd;
    logic              smp;
    logic [CountW-1:0] rep;
    logic [LagW-1:0]   lag;
    int unsigned       roll;
    for (int n = 0; n < count; n++) begin
      cmd = ($urandom_range(99) < 45) ? CmdRead : CmdAdvance;
      smp = $urandom_range(99) < 65;
      roll = $urandom_range(99);
      if (roll < 80) rep = CountW'($urandom_range(4));
      else if (roll < 95) rep = CountW'($urandom_range(40, 5));
      else rep = CountW'($urandom_range(255, 41));
      lag = ($urandom_range(99) < 85) ? LagW'($urandom_range(NumLags - 1))
                                      : LagW'($urandom_range(255, NumLags));
      send_item(cmd, smp, rep, lag);
    end
  endtask

  task automatic run_phase(input logic [DecayW-1:0] decay, input int unsigned mode,
                           input int unsigned count, input int unsigned hold);
    write_decay(decay);
    idle_mode = mode;
    hold_cycles = hold;
    run_random(count);
    drain();
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    command_i = CmdAdvance;
    sample_bit_i = 1'b0;
    repeat_count_i = '0;
    lag_select_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    idle_mode = IdleNone;
    hold_cycles = 0;
    sb = new();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Fresh state, out-of-range lags, ignored fields and a zero repeat count.
    read_lag(8'd0);
    read_lag(8'(NumLags - 1));
    read_lag(8'(NumLags));
    send_item(CmdRead, 1'b1, 8'd255, 8'd255);
    send_item(CmdAdvance, 1'b1, 8'd0, 8'd255);
    advance(1'b1, 8'd1);
    advance(1'b1, 8'd255);
    read_lag(8'd0);
    read_lag(8'(NumLags - 1));
    advance(1'b0, 8'd3);
    read_lag(8'd0);
    drain();

    // With the slowest decay a long run of set samples drives lag 1 into saturation.
    write_decay(16'hFFFF);
    for (int k = 0; k < 18; k++) advance(1'b1, 8'd255);
    read_lag(8'd0);
    read_lag(8'(NumLags - 1));
    drain();

    run_phase(16'h0000, IdleNone, 300, 400);
    run_phase(16'hFFFF, IdleSender, 300, 0);
    run_phase(16'($urandom_range(65535)), IdleReceiver, 300, 0);
    run_phase(16'h8000, IdleBoth, 300, 0);
    run_phase(16'($urandom_range(65535)), IdleBoth, 350, 0);

    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: files.f
sv/lba_pkg.sv
sv/lba_cell.sv
sv/leaky_binary_autocorrelation.sv
sv/lba_checker.sv
sim/leaky_binary_autocorrelation_tb.sv
